/* src/l6_frame_sync_reassembler_assert.svh */
// Assertion macros used by the checker of the frame reassembler.
`ifndef L6_FRAME_SYNC_REASSEMBLER_ASSERT_SVH
`define L6_FRAME_SYNC_REASSEMBLER_ASSERT_SVH

// Condition in this cycle implies a property in the same cycle.
`define L6_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition in this cycle implies a property in the next cycle.
`define L6_ASSERT_NXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* src/l6fsr_pkg.sv */
package l6fsr_pkg;

    localparam int MAX_FRAMES_DEF   = 8;
    localparam int STORE_BYTES_DEF  = 2048;
    localparam int NUM_CHANNELS_DEF = 3;

    localparam int FRAME_LEN = 218;
    localparam int HEAD_BITS = 49;
    localparam int DATA_BITS = 1695;
    localparam int Q_W       = 6;
    localparam int NUM_W     = 17;

    localparam logic [7:0] PRE0 = 8'h1A;
    localparam logic [7:0] PRE1 = 8'hCF;
    localparam logic [7:0] PRE2 = 8'hFC;
    localparam logic [7:0] PRE3 = 8'h1D;

    localparam logic [7:0] PRN_CH0 = 8'd200;
    localparam logic [7:0] PRN_CH1 = 8'd201;
    localparam logic [7:0] PRN_CH2 = 8'd197;

    localparam logic [2:0] VENDOR_RESET = 3'd2;

    localparam logic [2:0] ST_ABSORBED = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;

    typedef logic [7:0] byte_t;

endpackage

/* src/l6_frame_sync_reassembler.sv */
// Absorbed data byte: result in the cycle after the request is taken; one byte per cycle
// while the output is not stalled. Store read: store data registered, then result in S_RD.
// Frame end: unknown satellite answered from S_DEC, rejected or ignored header from S_EVAL,
// overflow from S_CHK after the count divider on a start; a stored subframe passes S_BASE,
// S_PRE, S_PRE2, a realigning copy of 212 or 213 bytes at one per cycle, and S_FIN.
// Reset clears sync, counts and the vendor register (to 2); buffers are not cleared.
module l6_frame_sync_reassembler #(
    parameter int MAX_FRAMES   = l6fsr_pkg::MAX_FRAMES_DEF,
    parameter int STORE_BYTES  = l6fsr_pkg::STORE_BYTES_DEF,
    parameter int NUM_CHANNELS = l6fsr_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  read_channel,
    input  logic [10:0] read_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  channel,
    output logic [3:0]  frames_total,
    output logic [3:0]  frame_index,
    output logic [1:0]  facility_id,
    output logic [7:0]  read_data
);
    import l6fsr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SA_W   = $clog2(NUM_CHANNELS * STORE_BYTES);
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BASE_W = $clog2(MAX_FRAMES * DATA_BITS + 8);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_EVAL = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_BASE = 4'd5;
    localparam logic [3:0] S_PRE  = 4'd6;
    localparam logic [3:0] S_PRE2 = 4'd7;
    localparam logic [3:0] S_COPY = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_RD   = 4'd10;

    byte_t frame_mem [FRAME_LEN];
    byte_t store_mem [NUM_CHANNELS * STORE_BYTES];

    logic [3:0]        state_reg;
    logic [7:0]        sync_reg;
    logic [2:0]        vendor_reg;
    byte_t             hdr_reg [12];
    logic [CNT_W-1:0]  exp_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]  sto_reg [NUM_CHANNELS];
    logic [CH_W-1:0]   cur_ch_reg;
    logic              rd_ch_ok_reg;
    logic              rd_addr_ok_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [Q_W-1:0]    q_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] wr_j_reg;
    logic [2:0]        sh_reg;
    byte_t             keep_reg;
    logic [7:0]        nd_reg;
    logic [7:0]        cnt_reg;
    logic [7:0]        rd_idx_reg;
    logic              first_reg;
    byte_t             prev_reg;
    byte_t             fr_rdata_reg;
    logic              fr_oob_reg;
    byte_t             st_rdata_reg;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [1:0]  channel_reg;
    logic [3:0]  frames_total_reg;
    logic [3:0]  frame_index_reg;
    logic [1:0]  facility_id_reg;
    byte_t       read_data_reg;

    logic              in_acc;
    logic              mism;
    logic              take;
    logic [7:0]        widx;
    logic [7:0]        sc_inc;
    logic              frame_end;
    logic              ch_ok;
    logic [CH_W-1:0]   ch_dec;
    logic [11:0]       msg_num;
    logic [15:0]       corlen;
    logic [4:0]        narea;
    logic [2:0]        vid;
    logic              si;
    logic              alert;
    logic [1:0]        fac;
    logic [CNT_W-1:0]  exp_c;
    logic [CNT_W-1:0]  sto_c;
    logic [CNT_W-1:0]  sto_n;
    logic [SA_W-1:0]   ch_base;
    logic [2:0]        b7;
    logic [5:0]        t0;
    logic [15:0]       pair_sh;
    byte_t             cur_b;
    byte_t             new_b;
    logic              rd_ok;

    logic              fr_we;
    logic              fr_re;
    logic [7:0]        fr_raddr;
    logic              st_re;
    logic              st_we;
    logic [SA_W-1:0]   st_raddr;
    logic [SA_W-1:0]   st_waddr;

    assign in_stall     = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc       = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign channel      = channel_reg;
    assign frames_total = frames_total_reg;
    assign frame_index  = frame_index_reg;
    assign facility_id  = facility_id_reg;
    assign read_data    = read_data_reg;

    // Preamble hunt; a 1A after a mismatch restarts the frame at byte zero.
    always_comb
    begin
        mism = (sync_reg == 8'd1 && data_byte != PRE1) ||
               (sync_reg == 8'd2 && data_byte != PRE2) ||
               (sync_reg == 8'd3 && data_byte != PRE3);
        take      = (sync_reg == 8'd0 || mism) ? (data_byte == PRE0) : 1'b1;
        widx      = (sync_reg == 8'd0 || mism) ? 8'd0 : sync_reg;
        sc_inc    = widx + 8'd1;
        frame_end = take && (sc_inc == 8'(FRAME_LEN));
    end

    always_comb
    begin
        ch_ok  = 1'b1;
        ch_dec = '0;
        if (hdr_reg[0] == PRN_CH0)
            ch_dec = CH_W'(0);
        else if (hdr_reg[0] == PRN_CH1)
            ch_dec = CH_W'(1);
        else if (hdr_reg[0] == PRN_CH2)
            ch_dec = CH_W'(2);
        else
            ch_ok = 1'b0;
        if ((hdr_reg[0] == PRN_CH1 && NUM_CHANNELS < 2) ||
            (hdr_reg[0] == PRN_CH2 && NUM_CHANNELS < 3))
            ch_ok = 1'b0;
    end

    assign vid     = hdr_reg[1][7:5];
    assign si      = hdr_reg[1][0];
    assign fac     = hdr_reg[1][4:3];
    assign alert   = hdr_reg[2][7];
    assign msg_num = {hdr_reg[2][6:0], hdr_reg[3][7:3]};
    assign corlen  = {hdr_reg[8][0], hdr_reg[9], hdr_reg[10][7:1]};
    assign narea   = {hdr_reg[10][0], hdr_reg[11][7:4]};
    assign exp_c   = exp_reg[cur_ch_reg];
    assign sto_c   = sto_reg[cur_ch_reg];
    assign sto_n   = slot_reg + CNT_W'(1);
    assign ch_base = SA_W'(int'(cur_ch_reg) * STORE_BYTES);
    assign b7      = base_reg[2:0];
    assign t0      = 6'(HEAD_BITS) - {3'b000, b7};
    assign rd_ok   = (int'(read_channel) < NUM_CHANNELS) && (int'(read_addr) < STORE_BYTES);

    // Realign: each store byte takes eight bits from two neighboring frame bytes.
    always_comb
    begin
        cur_b   = fr_oob_reg ? 8'h00 : fr_rdata_reg;
        pair_sh = {prev_reg, cur_b} << sh_reg;
        new_b   = pair_sh[15:8];
        if (first_reg)
            new_b = (st_rdata_reg & keep_reg) | (new_b & ~keep_reg);
    end

    always_comb
    begin
        fr_we    = in_acc && !cmd && take;
        fr_re    = 1'b0;
        fr_raddr = rd_idx_reg;
        st_re    = 1'b0;
        st_raddr = SA_W'(int'(read_channel) * STORE_BYTES) + SA_W'(read_addr);
        st_we    = 1'b0;
        st_waddr = ch_base + SA_W'(wr_j_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                st_re = in_acc && cmd && rd_ok;
            end
            S_PRE:
            begin
                st_re    = 1'b1;
                st_raddr = ch_base + SA_W'(base_reg >> 3);
                fr_re    = 1'b1;
                fr_raddr = {5'd0, t0[5:3]};
            end
            S_PRE2:
            begin
                fr_re = 1'b1;
            end
            S_COPY:
            begin
                fr_re = 1'b1;
                st_we = 1'b1;
            end
            default:
            begin
                fr_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
            frame_mem[widx] <= data_byte;
        if (fr_re)
        begin
            fr_oob_reg <= (int'(fr_raddr) >= FRAME_LEN);
            if (int'(fr_raddr) < FRAME_LEN)
                fr_rdata_reg <= frame_mem[fr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= new_b;
        if (st_re)
            st_rdata_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we && widx >= 8'd4 && widx <= 8'd15)
            hdr_reg[4'(widx - 8'd4)] <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sync_reg      <= 8'd0;
            vendor_reg    <= VENDOR_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                exp_reg[i] <= '0;
                sto_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                vendor_reg <= cfg_wdata;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && cmd)
                    begin
                        rd_ch_ok_reg   <= int'(read_channel) < NUM_CHANNELS;
                        rd_addr_ok_reg <= rd_ok;
                        cur_ch_reg     <= (int'(read_channel) < NUM_CHANNELS) ?
                                          CH_W'(read_channel) : '0;
                        state_reg      <= S_RD;
                    end
                    else if (in_acc)
                    begin
                        sync_reg <= (take && !frame_end) ? sc_inc : 8'd0;
                        if (frame_end)
                            state_reg <= S_DEC;
                        else
                        begin
                            out_valid_reg    <= 1'b1;
                            status_reg       <= ST_ABSORBED;
                            channel_reg      <= 2'd0;
                            frames_total_reg <= 4'd0;
                            frame_index_reg  <= 4'd0;
                            facility_id_reg  <= 2'd0;
                            read_data_reg    <= 8'd0;
                        end
                    end
                end
                S_RD:
                begin
                    out_valid_reg    <= 1'b1;
                    status_reg       <= ST_READ;
                    channel_reg      <= 2'(cur_ch_reg);
                    frames_total_reg <= rd_ch_ok_reg ? 4'(exp_c) : 4'd0;
                    frame_index_reg  <= rd_ch_ok_reg ? 4'(sto_c) : 4'd0;
                    facility_id_reg  <= 2'd0;
                    read_data_reg    <= rd_addr_ok_reg ? st_rdata_reg : 8'd0;
                    state_reg        <= S_IDLE;
                end
                S_DEC:
                begin
                    cur_ch_reg <= ch_dec;
                    if (!ch_ok)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= ST_REJECTED;
                        channel_reg      <= 2'd0;
                        frames_total_reg <= 4'd0;
                        frame_index_reg  <= 4'd0;
                        facility_id_reg  <= fac;
                        read_data_reg    <= 8'd0;
                        state_reg        <= S_IDLE;
                    end
                    else
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    channel_reg     <= 2'(cur_ch_reg);
                    facility_id_reg <= fac;
                    read_data_reg   <= 8'd0;
                    if (alert || vid != vendor_reg)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= alert ? ST_REJECTED : ST_IGNORED;
                        frames_total_reg <= 4'(exp_c);
                        frame_index_reg  <= 4'(sto_c);
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        if (si)
                            exp_reg[cur_ch_reg] <= '0;
                        if (si || exp_c == '0)
                        begin
                            if (msg_num != 12'd1)
                            begin
                                out_valid_reg    <= 1'b1;
                                status_reg       <= ST_IGNORED;
                                frames_total_reg <= 4'd0;
                                frame_index_reg  <= 4'(sto_c);
                                state_reg        <= S_IDLE;
                            end
                            else
                            begin
                                sto_reg[cur_ch_reg] <= '0;
                                num_reg   <= NUM_W'(75) + NUM_W'(narea) * NUM_W'(45) +
                                             NUM_W'(corlen);
                                q_reg     <= Q_W'(1);
                                state_reg <= S_DIV;
                            end
                        end
                        else
                        begin
                            slot_reg  <= sto_c;
                            total_reg <= exp_c;
                            state_reg <= S_BASE;
                        end
                    end
                end
                S_DIV:
                begin
                    if (num_reg >= NUM_W'(DATA_BITS))
                    begin
                        num_reg <= num_reg - NUM_W'(DATA_BITS);
                        q_reg   <= q_reg + Q_W'(1);
                    end
                    else
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (int'(q_reg) > MAX_FRAMES || int'(q_reg) * DATA_BITS > STORE_BYTES * 8)
                    begin
                        exp_reg[cur_ch_reg] <= '0;
                        out_valid_reg       <= 1'b1;
                        status_reg          <= ST_OVERFLOW;
                        frames_total_reg    <= 4'd0;
                        frame_index_reg     <= 4'd0;
                        state_reg           <= S_IDLE;
                    end
                    else
                    begin
                        exp_reg[cur_ch_reg] <= CNT_W'(q_reg);
                        total_reg           <= CNT_W'(q_reg);
                        slot_reg            <= '0;
                        state_reg           <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    base_reg  <= BASE_W'(int'(slot_reg) * DATA_BITS);
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    sh_reg     <= t0[2:0];
                    keep_reg   <= ~(8'hFF >> b7);
                    nd_reg     <= 8'((int'(b7) + DATA_BITS - 1) / 8 + 1);
                    wr_j_reg   <= base_reg >> 3;
                    rd_idx_reg <= {5'd0, t0[5:3]} + 8'd1;
                    cnt_reg    <= 8'd0;
                    first_reg  <= 1'b1;
                    state_reg  <= S_PRE2;
                end
                S_PRE2:
                begin
                    prev_reg   <= cur_b;
                    rd_idx_reg <= rd_idx_reg + 8'd1;
                    state_reg  <= S_COPY;
                end
                S_COPY:
                begin
                    prev_reg   <= cur_b;
                    first_reg  <= 1'b0;
                    rd_idx_reg <= rd_idx_reg + 8'd1;
                    wr_j_reg   <= wr_j_reg + BASE_W'(1);
                    cnt_reg    <= cnt_reg + 8'd1;
                    if (cnt_reg == nd_reg - 8'd1)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    sto_reg[cur_ch_reg] <= sto_n;
                    if (sto_n >= total_reg)
                        exp_reg[cur_ch_reg] <= '0;
                    out_valid_reg    <= 1'b1;
                    status_reg       <= (sto_n >= total_reg) ? ST_COMPLETE : ST_STORED;
                    frames_total_reg <= 4'(total_reg);
                    frame_index_reg  <= 4'(sto_n);
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/l6fsr_checker.sv */
`include "l6_frame_sync_reassembler_assert.svh"

module l6fsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [1:0]  channel,
    input logic [3:0]  frames_total,
    input logic [3:0]  frame_index,
    input logic [7:0]  read_data
);
    import l6fsr_pkg::*;

    // A held result keeps its status.
    `L6_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status), "result changed while stalled")

    // No request is taken while a result waits.
    `L6_ASSERT_IMP(a_full, clk, rst_n, out_valid && out_stall, in_stall, "request taken while a result waits")

    // Store data only shows up on a read result.
    `L6_ASSERT_IMP(a_rdata, clk, rst_n, out_valid && status != ST_READ, read_data == 8'd0, "read data outside a read result")

    // An absorbed byte carries no channel state.
    `L6_ASSERT_IMP(a_absorb, clk, rst_n, out_valid && status == ST_ABSORBED, channel == 2'd0 && frames_total == 4'd0 && frame_index == 4'd0, "absorbed result with fields set")

    // A partial message has fewer stored subframes than it spans.
    `L6_ASSERT_IMP(a_partial, clk, rst_n, out_valid && status == ST_STORED, frame_index < frames_total && frame_index != 4'd0, "stored count out of range")

endmodule

bind l6_frame_sync_reassembler l6fsr_checker u_l6fsr_checker (.*);
